[rtl/core/lfsc_pkg.sv]
// shared constants and types for the line-follow steering controller
package lfsc_pkg;

  localparam int SECOND_ERROR_WIDTH = 12;

  localparam int BASE_SPEED   = 80;
  localparam int MAX_SPEED    = 180;
  localparam int FIRST_LIMIT  = 25;
  localparam int SECOND_STEP  = 6;
  localparam int NARROW_BAND  = 5;
  localparam int MID_BAND     = 10;
  localparam int GAIN_NARROW  = 512;
  localparam int GAIN_MID     = 1792;
  localparam int GAIN_RESET   = 256;
  localparam int GAIN_W       = 16;

  localparam logic [7:0] MARK_CORNER = 8'hff;
  localparam logic [7:0] MARK_STOP   = 8'hee;
  localparam logic [7:0] SIGN_NEG    = 8'h00;
  localparam logic [7:0] SIGN_POS    = 8'h01;

  localparam logic [7:0] CORNER_OFF    = 8'd1;
  localparam logic [7:0] CORNER_RESUME = 8'd2;

  localparam logic CMD_PACKET = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  localparam logic REG_FIRST_GAIN  = 1'b0;
  localparam logic REG_SECOND_GAIN = 1'b1;

  typedef struct packed {
    logic pkt;
    logic tick;
  } lfsc_step_t;

endpackage

[rtl/core/lfsc_err_state.sv]
// error, marker and steering state with per-beat update logic
module lfsc_err_state #(
  parameter int SE_W = lfsc_pkg::SECOND_ERROR_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lfsc_pkg::lfsc_step_t     step,
  input  logic [7:0]               first_sign,
  input  logic [7:0]               first_magnitude,
  input  logic [7:0]               second_sign,
  input  logic [7:0]               second_magnitude,
  input  logic [lfsc_pkg::GAIN_W-1:0] gain_wide,
  output logic signed [8:0]        tick_fe,
  output logic signed [SE_W-1:0]   tick_se,
  output logic [lfsc_pkg::GAIN_W-1:0] tick_gain2,
  output logic                     tick_steer,
  output logic [7:0]               tick_stops
);
  import lfsc_pkg::*;

  localparam logic signed [SE_W-1:0] SE_LOWEST = {1'b1, {(SE_W-1){1'b0}}};
  localparam logic signed [SE_W:0]   SE_LOWEST_X = {1'b1, SE_LOWEST};
  localparam logic signed [SE_W-1:0] SE_NARROW = SE_W'(NARROW_BAND);
  localparam logic signed [SE_W-1:0] SE_MID = SE_W'(MID_BAND);
  localparam logic signed [8:0]      FE_LIM = 9'(FIRST_LIMIT);

  logic signed [8:0]      fe_r, fe_nxt;
  logic signed [SE_W-1:0] se_r, se_nxt;
  logic [7:0]             corner_r, corner_nxt;
  logic                   steer_r, steer_nxt;
  logic [7:0]             stop_r, stop_nxt;

  logic                   is_corner, is_stop;
  logic [7:0]             corner_inc;
  logic signed [8:0]      fe_pos;
  logic signed [SE_W-1:0] se_pos;
  logic signed [SE_W:0]   se_dec;
  logic signed [SE_W-1:0] se_sat;
  logic                   fe_big;

  assign is_corner  = (first_sign == MARK_CORNER) && (first_magnitude == MARK_CORNER);
  assign is_stop    = (first_sign == MARK_STOP) && (first_magnitude == MARK_STOP);
  assign corner_inc = corner_r + 8'd1;
  assign fe_pos     = $signed({1'b0, first_magnitude});
  assign se_pos     = $signed({{(SE_W-8){1'b0}}, second_magnitude});

  // saturating step down of the second error
  assign se_dec = $signed({se_r[SE_W-1], se_r}) - $signed((SE_W+1)'(SECOND_STEP));
  assign se_sat = (se_dec < SE_LOWEST_X) ? SE_LOWEST : se_dec[SE_W-1:0];
  assign fe_big = (fe_r > FE_LIM) || (fe_r < -FE_LIM);

  assign tick_fe    = fe_big ? 9'sd0 : fe_r;
  assign tick_se    = se_sat;
  assign tick_steer = steer_r;
  assign tick_stops = stop_r;

  always_comb begin
    if ((se_r <= SE_NARROW) && (se_r >= -SE_NARROW)) begin
      tick_gain2 = GAIN_W'(GAIN_NARROW);
    end else if ((se_r <= SE_MID) && (se_r >= -SE_MID)) begin
      tick_gain2 = GAIN_W'(GAIN_MID);
    end else begin
      tick_gain2 = gain_wide;
    end
  end

  always_comb begin
    fe_nxt     = fe_r;
    se_nxt     = se_r;
    corner_nxt = corner_r;
    steer_nxt  = steer_r;
    stop_nxt   = stop_r;
    if (step.pkt) begin
      if (is_corner) begin
        corner_nxt = corner_inc;
        fe_nxt     = '0;
        se_nxt     = '0;
        if ((corner_inc == CORNER_OFF) || (corner_inc == CORNER_RESUME)) begin
          steer_nxt = (corner_inc == CORNER_RESUME);
        end else if (second_sign == SIGN_NEG) begin
          se_nxt = -se_pos;
        end else if (second_sign == SIGN_POS) begin
          se_nxt = se_pos;
        end
      end else if (is_stop) begin
        stop_nxt = stop_r + 8'd1;
        fe_nxt   = '0;
        se_nxt   = '0;
      end else begin
        if (first_sign == SIGN_NEG) begin
          fe_nxt = -fe_pos;
        end else if (first_sign == SIGN_POS) begin
          fe_nxt = fe_pos;
        end
        if (second_sign == SIGN_NEG) begin
          se_nxt = -se_pos;
        end else if (second_sign == SIGN_POS) begin
          se_nxt = se_pos;
        end
      end
    end else if (step.tick) begin
      fe_nxt = tick_fe;
      se_nxt = se_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fe_r     <= '0;
      se_r     <= '0;
      corner_r <= '0;
      steer_r  <= 1'b1;
      stop_r   <= '0;
    end else begin
      fe_r     <= fe_nxt;
      se_r     <= se_nxt;
      corner_r <= corner_nxt;
      steer_r  <= steer_nxt;
      stop_r   <= stop_nxt;
    end
  end

endmodule

[rtl/core/line_follow_steering_control_top.sv]
// line-follow steering controller: top level with gain registers and speed pipeline
//
// Input channel (in_valid / in_stall) takes two kinds of beat. A sensor packet
// (in_command 0) updates the stored errors and the corner and stop marker counts
// and gives no result. A control tick (in_command 1) gives exactly one result
// beat on the output channel (out_valid / out_stall) with left and right wheel
// speeds in 0..180 and the running stop marker count.
// A tick result passes through the input stage, loaded at the accepting edge,
// then the multiply stage, then sum and clamp into the output register. One
// beat per cycle is taken while in_stall is low; packets and ticks may be
// mixed freely.
// When the receiver stalls, the three stages keep filling; in_stall rises
// only once all of them hold tick results.
// cfg_we writes gain register cfg_index (0 first gain, 1 wide second gain,
// unsigned Q8.8) from cfg_wdata; write only while no tick is in flight.
// Synchronous reset clears the errors and counts, turns steering on, sets
// both gains to 1.0 and empties the pipeline.
module line_follow_steering_control_top #(
  parameter int SECOND_ERROR_WIDTH = lfsc_pkg::SECOND_ERROR_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_command,
  input  logic [7:0]                  in_first_sign,
  input  logic [7:0]                  in_first_magnitude,
  input  logic [7:0]                  in_second_sign,
  input  logic [7:0]                  in_second_magnitude,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_left_speed,
  output logic [7:0]                  out_right_speed,
  output logic [7:0]                  out_stop_markers_seen,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [lfsc_pkg::GAIN_W-1:0] cfg_wdata
);
  import lfsc_pkg::*;

  localparam int SE_W   = SECOND_ERROR_WIDTH;
  localparam int P1_W   = 9 + GAIN_W + 1;
  localparam int P2_W   = SE_W + GAIN_W + 1;
  localparam int SUM_W  = P2_W + 1;
  localparam int T_W    = SUM_W + 1;
  localparam logic signed [T_W-1:0] BASE_SCALED = T_W'(BASE_SPEED * 256);

  logic [GAIN_W-1:0] first_gain_r, second_gain_r;

  lfsc_step_t             step;
  logic                   accept;
  logic                   out_ready, p2_adv, p1_adv;

  logic signed [8:0]      tick_fe;
  logic signed [SE_W-1:0] tick_se;
  logic [GAIN_W-1:0]      tick_gain2;
  logic                   tick_steer;
  logic [7:0]             tick_stops;

  logic                   p1_v_r;
  logic signed [8:0]      p1_fe_r;
  logic signed [SE_W-1:0] p1_se_r;
  logic [GAIN_W-1:0]      p1_g2_r;
  logic                   p1_steer_r;
  logic [7:0]             p1_stop_r;

  logic                   p2_v_r;
  logic signed [P1_W-1:0] p2_prod1_r, prod1;
  logic signed [P2_W-1:0] p2_prod2_r, prod2;
  logic [7:0]             p2_stop_r;

  logic signed [SUM_W-1:0] sum;
  logic signed [T_W-1:0]   t_left, t_right;

  logic                   out_valid_r;
  logic [7:0]             left_r, right_r, stops_r;

  function automatic logic [7:0] clamp_speed(input logic signed [T_W-1:0] t);
    logic [T_W-9:0] q;
    q = t[T_W-1:8];
    if (t[T_W-1]) begin
      return 8'd0;
    end else if (q > (T_W-8)'(MAX_SPEED)) begin
      return 8'(MAX_SPEED);
    end else begin
      return q[7:0];
    end
  endfunction

  // per-stage advance so the pipe keeps filling behind a stalled result
  assign out_ready = !out_valid_r || !out_stall;
  assign p2_adv    = !p2_v_r || out_ready;
  assign p1_adv    = !p1_v_r || p2_adv;
  assign in_stall  = !p1_adv;
  assign accept    = in_valid && p1_adv;
  assign step.pkt  = accept && (in_command == CMD_PACKET);
  assign step.tick = accept && (in_command == CMD_TICK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_gain_r  <= GAIN_W'(GAIN_RESET);
      second_gain_r <= GAIN_W'(GAIN_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIRST_GAIN:  first_gain_r  <= cfg_wdata;
        REG_SECOND_GAIN: second_gain_r <= cfg_wdata;
        default:         first_gain_r  <= first_gain_r;
      endcase
    end
  end

  lfsc_err_state #(
    .SE_W(SE_W)
  ) u_state (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (step),
    .first_sign       (in_first_sign),
    .first_magnitude  (in_first_magnitude),
    .second_sign      (in_second_sign),
    .second_magnitude (in_second_magnitude),
    .gain_wide        (second_gain_r),
    .tick_fe          (tick_fe),
    .tick_se          (tick_se),
    .tick_gain2       (tick_gain2),
    .tick_steer       (tick_steer),
    .tick_stops       (tick_stops)
  );

  // stage 1: snapshot of the tick's working values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (p1_adv) begin
      p1_v_r <= step.tick;
    end
  end

  always_ff @(posedge clk) begin
    if (step.tick) begin
      p1_fe_r    <= tick_fe;
      p1_se_r    <= tick_se;
      p1_g2_r    <= tick_gain2;
      p1_steer_r <= tick_steer;
      p1_stop_r  <= tick_stops;
    end
  end

  // stage 2: the two gain products, zeroed while steering is off
  assign prod1 = P1_W'(p1_fe_r) * P1_W'($signed({1'b0, first_gain_r}));
  assign prod2 = P2_W'(p1_se_r) * P2_W'($signed({1'b0, p1_g2_r}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
    end else if (p2_adv) begin
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p2_adv && p1_v_r) begin
      p2_prod1_r <= p1_steer_r ? prod1 : '0;
      p2_prod2_r <= p1_steer_r ? prod2 : '0;
      p2_stop_r  <= p1_stop_r;
    end
  end

  // stage 3: sum, offset by base speed, truncate and clamp
  assign sum     = SUM_W'(p2_prod1_r) + SUM_W'(p2_prod2_r);
  assign t_left  = BASE_SCALED + T_W'(sum);
  assign t_right = BASE_SCALED - T_W'(sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && p2_v_r) begin
      left_r  <= clamp_speed(t_left);
      right_r <= clamp_speed(t_right);
      stops_r <= p2_stop_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_left_speed        = left_r;
  assign out_right_speed       = right_r;
  assign out_stop_markers_seen = stops_r;

`ifndef ASSERT_OFF
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (p1_v_r && p2_v_r && out_valid_r))
    else $error("input stalled with an empty pipeline stage");

  a_tick_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    step.tick |=> p1_v_r)
    else $error("accepted tick did not enter stage 1");

  a_speed_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_left_speed <= 8'(MAX_SPEED)) && (out_right_speed <= 8'(MAX_SPEED))))
    else $error("wheel speed out of range");
`endif

endmodule
